FILE: rtl/core/vectored_interrupt_controller_macros.svh
// assertion helpers shared by the controller rtl
`ifndef VECTORED_INTERRUPT_CONTROLLER_MACROS_SVH
`define VECTORED_INTERRUPT_CONTROLLER_MACROS_SVH

// same-cycle implication, checked out of reset
`define VIC_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define VIC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/vic_pkg.sv
package vic_pkg;

	typedef enum logic [1:0] {
		KIND_TICK  = 2'd0,
		KIND_WRITE = 2'd1,
		KIND_READ  = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		REG_ISR = 3'd0,
		REG_IPR = 3'd1,
		REG_IER = 3'd2,
		REG_IAR = 3'd3,
		REG_SIE = 3'd4,
		REG_CIE = 3'd5,
		REG_IVR = 3'd6,
		REG_MER = 3'd7
	} reg_index_t;

	localparam int MER_ME  = 0;
	localparam int MER_HIE = 1;

	localparam int          APB_ADDR_W = 2;
	localparam logic [31:0] NO_VECTOR  = 32'hffff_ffff;

endpackage

FILE: rtl/core/vic_if.sv
interface vic_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [2:0]  reg_index;
	logic [31:0] write_data;
	logic [31:0] irq_lines;

	modport source (output valid, kind, reg_index, write_data, irq_lines, input ready);
	modport sink (input valid, kind, reg_index, write_data, irq_lines, output ready);
endinterface

interface vic_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] read_data;
	logic        irq_out;

	modport source (output valid, read_data, irq_out, input ready);
	modport sink (input valid, read_data, irq_out, output ready);
endinterface

FILE: rtl/core/vectored_interrupt_controller.sv
// the result word is registered and valid in the cycle after the edge that accepts its input word
// throughput: one word per cycle while each result is taken; the result register frees as its word is taken
// all state updates and the vector encode are combinational logic before the result register
// reset (arst_n low, asynchronous) clears status, enable, master, last sample, edge mask
// and the result valid flag
module vectored_interrupt_controller #(
	parameter int NUM_INPUTS = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [vic_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready,
	vic_req_if.sink                         req,
	vic_rsp_if.source                       rsp
);

	import vic_pkg::*;
	`include "vectored_interrupt_controller_macros.svh"

	localparam int IdxW = (NUM_INPUTS > 1) ? $clog2(NUM_INPUTS) : 1;

	logic [NUM_INPUTS-1:0] edge_q;
	logic [NUM_INPUTS-1:0] status_q, status_n;
	logic [NUM_INPUTS-1:0] enable_q, enable_n;
	logic [NUM_INPUTS-1:0] last_q, last_n;
	logic [1:0]            master_q, master_n;
	logic [NUM_INPUTS-1:0] data_m, lines_m, rising, pend;
	logic                  vec_found;
	logic [IdxW-1:0]       vec_idx;
	logic [31:0]           rd_n;
	logic                  irq_n;
	logic                  req_acc;
	logic                  rsp_valid_q;
	logic [31:0]           rd_q;
	logic                  irq_q;
	kind_t                 kind;
	reg_index_t            reg_sel;

	// config port
	assign pready = 1'b1;
	assign prdata = 32'(edge_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_q <= '0;
		end else if (psel && penable && pwrite) begin
			edge_q <= pwdata[NUM_INPUTS-1:0];
		end
	end

	// handshake
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign req_acc   = req.valid && req.ready;

	assign kind    = kind_t'(req.kind);
	assign reg_sel = reg_index_t'(req.reg_index);
	assign data_m  = req.write_data[NUM_INPUTS-1:0];
	assign lines_m = req.irq_lines[NUM_INPUTS-1:0];
	assign rising  = lines_m & ~last_q;
	assign pend    = status_q & enable_q;

	vic_prio_enc #(
		.WIDTH (NUM_INPUTS)
	) u_prio_enc (
		.bits  (pend),
		.found (vec_found),
		.idx   (vec_idx)
	);

	always_comb begin
		status_n = status_q;
		enable_n = enable_q;
		master_n = master_q;
		last_n   = last_q;
		rd_n     = '0;
		case (kind)
			KIND_TICK: begin
				status_n = status_q | (edge_q & rising) | (~edge_q & lines_m);
				last_n   = lines_m;
			end
			KIND_WRITE: begin
				unique case (reg_sel)
					REG_ISR: begin
						if (!master_q[MER_HIE]) begin
							status_n = status_q | data_m;
						end
					end
					REG_IER: enable_n = data_m;
					REG_IAR: status_n = status_q & ~data_m;
					REG_SIE: enable_n = enable_q | data_m;
					REG_CIE: enable_n = enable_q & ~data_m;
					REG_MER: master_n = req.write_data[1:0];
					REG_IPR, REG_IVR: ;
					default: ;
				endcase
			end
			KIND_READ: begin
				unique case (reg_sel)
					REG_ISR: rd_n = 32'(status_q);
					REG_IPR: rd_n = 32'(pend);
					REG_IER: rd_n = 32'(enable_q);
					REG_IVR: rd_n = vec_found ? 32'(vec_idx) : NO_VECTOR;
					REG_MER: rd_n = 32'(master_q);
					REG_IAR, REG_SIE, REG_CIE: rd_n = '0;
					default: rd_n = '0;
				endcase
			end
			default: ;
		endcase
		irq_n = master_n[MER_ME] && master_n[MER_HIE] && (|(status_n & enable_n));
	end

	// interrupt state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q <= '0;
			enable_q <= '0;
			master_q <= '0;
			last_q   <= '0;
		end else if (req_acc) begin
			status_q <= status_n;
			enable_q <= enable_n;
			master_q <= master_n;
			last_q   <= last_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (req_acc) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			rd_q  <= rd_n;
			irq_q <= irq_n;
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.read_data = rd_q;
	assign rsp.irq_out   = irq_q;

	`VIC_ASSERT_SAME(a_irq_matches_state, rsp.valid && rsp.irq_out,
		master_q[MER_ME] && master_q[MER_HIE] && ((status_q & enable_q) != '0),
		"irq word without enabled pending input")
	`VIC_ASSERT_NEXT(a_level_tick_sets, req_acc && (kind == KIND_TICK),
		(status_q & $past(lines_m & ~edge_q)) == $past(lines_m & ~edge_q),
		"level line high on tick did not set status")
	`VIC_ASSERT_NEXT(a_iar_clears, req_acc && (kind == KIND_WRITE) && (reg_sel == REG_IAR),
		(status_q & $past(data_m)) == '0,
		"iar write left status bits set")

endmodule

FILE: rtl/core/vic_prio_enc.sv
module vic_prio_enc #(
	parameter int WIDTH = 32,
	localparam int IdxW = (WIDTH > 1) ? $clog2(WIDTH) : 1
) (
	input  logic [WIDTH-1:0] bits,
	output logic             found,
	output logic [IdxW-1:0]  idx
);

	// lowest set bit wins
	always_comb begin
		found = |bits;
		idx   = '0;
		for (int i = WIDTH - 1; i >= 0; i--) begin
			if (bits[i]) begin
				idx = IdxW'(i);
			end
		end
	end

endmodule
